>>> hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types and constants of the frustum box cull test
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PlaneIdxW   = 3;
  localparam int CoordW      = 16;
  localparam int PlaneW      = 64;

  // plane register indexes
  localparam logic [PlaneIdxW-1:0] PL_LEFT   = 3'd0;
  localparam logic [PlaneIdxW-1:0] PL_RIGHT  = 3'd1;
  localparam logic [PlaneIdxW-1:0] PL_BOTTOM = 3'd2;
  localparam logic [PlaneIdxW-1:0] PL_TOP    = 3'd3;
  localparam logic [PlaneIdxW-1:0] PL_NEAR   = 3'd4;
  localparam logic [PlaneIdxW-1:0] PL_FAR    = 3'd5;

  // position codes
  localparam logic [1:0] POS_OUTSIDE = 2'd0;
  localparam logic [1:0] POS_AROUND  = 2'd1;
  localparam logic [1:0] POS_INSIDE  = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [PlaneIdxW-1:0]     start_plane;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           position;
    logic [PlaneIdxW-1:0] culling_plane;
  } out_item_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // per-plane test outcome
  typedef struct packed {
    logic all_back;
    logic lo_back;
    logic hi_back;
  } plane_flags_t;

endpackage

>>> hdl/frustum_box_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_test
// axis-aligned box test against six frustum planes; unless the output stalls, one box per cycle
// ----------------------------------------------------------------------------
// usage
// - config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   one plane per transaction: 0 left, 1 right, 2 bottom, 3 top, 4 near,
//   5 far; indexes 6 and 7 are dropped. cfg_ready_o is always high. write
//   planes only while no box is in flight
// - input channel (in_valid_i/in_ready_o) takes one box plus the start plane
//   per transaction; output channel (out_valid_o/out_ready_i) returns one
//   position and culling plane per box, in order
// - pipeline: products load at the edge that accepts a box, then partial
//   sums, corner signs and decision are registered in turn, and the result
//   shows on out_valid_o; throughput one box per cycle while out_ready_i
//   does not stall, set by the four-stage pipe with 36 16x16 multipliers
//   in the product stage
// - reset clears all stage valid bits and all planes to zero
// - when the receiver stalls, bubbles in the pipe are squeezed out first;
//   in_ready_o drops only once all four stages hold a box
// ----------------------------------------------------------------------------
module frustum_box_cull_test import fbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // plane configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [PlaneIdxW-1:0] cfg_index_i,
  input  logic [PlaneW-1:0]    cfg_data_i,
  // boxes in
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  // results out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  // plane registers, each feeds its own unit
  logic [PlaneW-1:0] plane_q [PLANE_COUNT];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane_q[p] <= '0;
      end
    end else if (cfg_valid_i && cfg_index_i < PlaneIdxW'(PLANE_COUNT)) begin
      plane_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // stage valid bits; a stage loads when empty or when the next one loads
  logic     v1_q, v2_q, v3_q, v4_q;
  pipe_en_t en;

  always_comb begin
    en.s4 = !v4_q || out_ready_i;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  // start plane rides along with the box
  logic [PlaneIdxW-1:0] start1_q, start2_q, start3_q;

  always_ff @(posedge clk_i) begin
    if (en.s1) start1_q <= in_item_i.start_plane;
    if (en.s2) start2_q <= start1_q;
    if (en.s3) start3_q <= start2_q;
  end

  // one evaluation pipe per plane
  plane_flags_t flags [PLANE_COUNT];

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fbc_plane_unit u_plane (
      .clk_i   (clk_i),
      .plane_i (plane_q[p]),
      .box_i   (in_item_i),
      .en_i    (en),
      .flags_o (flags[p])
    );
  end

  // decision stage doubles as the output register
  fbc_decide u_decide (
    .clk_i    (clk_i),
    .load_i   (en.s4),
    .flags_i  (flags),
    .start_i  (start3_q),
    .result_o (out_item_o)
  );

  assign out_valid_o = v4_q;

  // input backpressure only when every stage is occupied and output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !out_ready_i))
    else $error("input stalled with a free stage");

  // a box moving from stage 1 into stage 2 shows up there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en.s2) |=> v2_q)
    else $error("box lost between stage 1 and 2");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.position == POS_OUTSIDE ||
                     out_item_o.position == POS_AROUND ||
                     out_item_o.position == POS_INSIDE))
    else $error("bad position code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.position != POS_OUTSIDE) |->
      (out_item_o.culling_plane == '0))
    else $error("culling plane set without rejection");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.culling_plane < PlaneIdxW'(PLANE_COUNT)))
    else $error("culling plane out of range");

endmodule

>>> hdl/fbc_plane_unit.sv
// ----------------------------------------------------------------------------
// fbc_plane_unit
// three-stage evaluation of the eight box corners against one plane
// ----------------------------------------------------------------------------
module fbc_plane_unit import fbc_pkg::*; (
  input  logic                clk_i,
  input  logic [PlaneW-1:0]   plane_i,
  input  in_item_t            box_i,
  input  pipe_en_t            en_i,
  output plane_flags_t        flags_o
);

  logic signed [15:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [29:0] d_al;

  assign coef_a = $signed(plane_i[15:0]);
  assign coef_b = $signed(plane_i[31:16]);
  assign coef_c = $signed(plane_i[47:32]);
  assign coef_d = $signed(plane_i[63:48]);
  assign d_al   = {coef_d, 14'b0};

  // stage 1: products, index 0 min and 1 max
  logic signed [31:0] prod_x_q [2];
  logic signed [31:0] prod_y_q [2];
  logic signed [31:0] prod_z_q [2];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_x_q[0] <= 32'(coef_a * box_i.min_x);
      prod_x_q[1] <= 32'(coef_a * box_i.max_x);
      prod_y_q[0] <= 32'(coef_b * box_i.min_y);
      prod_y_q[1] <= 32'(coef_b * box_i.max_y);
      prod_z_q[0] <= 32'(coef_c * box_i.min_z);
      prod_z_q[1] <= 32'(coef_c * box_i.max_z);
    end
  end

  // stage 2: xy partial sums (bit 0 x, bit 1 y) and z plus offset
  logic signed [32:0] sum_xy_q [4];
  logic signed [32:0] sum_z_q  [2];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sum_xy_q[0] <= 33'(prod_x_q[0]) + 33'(prod_y_q[0]);
      sum_xy_q[1] <= 33'(prod_x_q[1]) + 33'(prod_y_q[0]);
      sum_xy_q[2] <= 33'(prod_x_q[0]) + 33'(prod_y_q[1]);
      sum_xy_q[3] <= 33'(prod_x_q[1]) + 33'(prod_y_q[1]);
      sum_z_q[0]  <= 33'(prod_z_q[0]) + 33'(d_al);
      sum_z_q[1]  <= 33'(prod_z_q[1]) + 33'(d_al);
    end
  end

  // stage 3: full sum per corner, sign gives behind
  logic signed [33:0] acc [8];
  logic [7:0]         behind;

  for (genvar g = 0; g < 8; g++) begin : g_corner
    assign acc[g]    = 34'(sum_xy_q[g % 4]) + 34'(sum_z_q[g / 4]);
    assign behind[g] = acc[g][33];
  end

  plane_flags_t flags_d, flags_q;

  always_comb begin
    flags_d.all_back = &behind;
    flags_d.lo_back  = behind[0];
    flags_d.hi_back  = behind[7];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

>>> hdl/fbc_decide.sv
// ----------------------------------------------------------------------------
// fbc_decide
// picks the rejecting plane in visit order, else around or inside
// ----------------------------------------------------------------------------
module fbc_decide import fbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  plane_flags_t          flags_i [PLANE_COUNT],
  input  logic [PlaneIdxW-1:0]  start_i,
  output out_item_t             result_o
);

  logic [PlaneIdxW-1:0] start_w;
  logic [PlaneIdxW:0]   idx;
  logic                 hit;
  logic [PlaneIdxW-1:0] pick;
  logic                 span_x, span_y, span_z;
  out_item_t            result_d, result_q;

  always_comb begin
    // starts past the last plane wrap
    start_w = (start_i >= PlaneIdxW'(PLANE_COUNT)) ? start_i - PlaneIdxW'(PLANE_COUNT)
                                                   : start_i;
    hit  = 1'b0;
    pick = '0;
    idx  = '0;
    // walk backward so the earliest visited plane wins
    for (int k = PLANE_COUNT - 1; k >= 0; k--) begin
      idx = (PlaneIdxW+1)'(start_w) + (PlaneIdxW+1)'(k);
      if (idx >= (PlaneIdxW+1)'(PLANE_COUNT)) begin
        idx = idx - (PlaneIdxW+1)'(PLANE_COUNT);
      end
      if (flags_i[idx[PlaneIdxW-1:0]].all_back) begin
        hit  = 1'b1;
        pick = idx[PlaneIdxW-1:0];
      end
    end

    span_x = (flags_i[PL_LEFT].lo_back && flags_i[PL_RIGHT].hi_back) ||
             (flags_i[PL_RIGHT].lo_back && flags_i[PL_LEFT].hi_back);
    span_y = (flags_i[PL_TOP].lo_back && flags_i[PL_BOTTOM].hi_back) ||
             (flags_i[PL_BOTTOM].lo_back && flags_i[PL_TOP].hi_back);
    span_z = (flags_i[PL_NEAR].lo_back && flags_i[PL_FAR].hi_back) ||
             (flags_i[PL_FAR].lo_back && flags_i[PL_NEAR].hi_back);

    if (hit) begin
      result_d.position      = POS_OUTSIDE;
      result_d.culling_plane = pick;
    end else begin
      result_d.position      = (span_x && span_y && span_z) ? POS_AROUND : POS_INSIDE;
      result_d.culling_plane = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule
